/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold whenever ante holds
`define ASSERT_IMPLIES(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("implication check failed");

// cond must never hold
`define ASSERT_NEVER(name, ck, rn, cond) \
    name: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
        else $error("forbidden condition seen");

`endif

/* hw/rtl/scs_pkg.sv */
// ----------------------------------------------------------------------------
// scs_pkg
// Types and constants shared by the cylinder splitter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scs_pkg;

    localparam logic [1:0] CFG_SPT   = 2'd0;
    localparam logic [1:0] CFG_HEADS = 2'd1;
    localparam logic [1:0] CFG_CYLS  = 2'd2;

    localparam logic [5:0] SPT_RESET   = 6'd18;
    localparam logic [1:0] HEADS_RESET = 2'd2;
    localparam logic [7:0] CYLS_RESET  = 8'd80;

    localparam int QUEUE_DEPTH = 2;
    localparam int DIV_STEPS   = 16;

    typedef enum logic [0:0] {
        REQ_NORMAL,
        REQ_ERROR
    } req_kind_t;

    typedef struct packed {
        req_kind_t   kind;
        logic [1:0]  drive;
        logic [15:0] lba;
        logic [6:0]  count;
    } req_t;

    typedef struct packed {
        logic [5:0] spt;
        logic [1:0] heads;
        logic [7:0] cyls;
    } geom_t;

    typedef struct packed {
        logic       head;
        logic [7:0] track;
        logic [5:0] sector;
        logic [6:0] chunk;
        logic [2:0] sel;
        logic       bad;
        logic       last;
    } result_t;

endpackage

/* hw/rtl/scs_front.sv */
// ----------------------------------------------------------------------------
// scs_front
// Input stage: takes requests, saturates the count, drops empty requests
// and tags requests that hit a zero geometry as errors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scs_front
    import scs_pkg::*;
#(
    parameter int MAX_COUNT = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  geom_t       geom,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  in_drive,
    input  logic [15:0] in_lba,
    input  logic [6:0]  in_count,
    output logic        out_valid,
    input  logic        out_ready,
    output req_t        out_req
);

    logic       valid_reg;
    req_t       req_reg;
    req_t       req_next;
    logic       accept;
    logic [6:0] count_sat;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_req   = req_reg;

    assign count_sat = (in_count > 7'(MAX_COUNT)) ? 7'(MAX_COUNT) : in_count;

    always_comb
    begin
        req_next.kind  = (geom.spt == 6'd0 || geom.heads == 2'd0) ? REQ_ERROR : REQ_NORMAL;
        req_next.drive = in_drive;
        req_next.lba   = in_lba;
        req_next.count = count_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= (in_count != 7'd0);
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_next;
        end
    end

endmodule

/* hw/rtl/scs_queue.sv */
// ----------------------------------------------------------------------------
// scs_queue
// Short request queue between the input stage and the chunk engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scs_queue
    import scs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_req,
    output logic out_valid,
    input  logic out_ready,
    output req_t out_req
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    req_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              push;
    logic              pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign in_ready  = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_req   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

/* hw/rtl/scs_div.sv */
// ----------------------------------------------------------------------------
// scs_div
// Restoring divider, 16-bit dividend by 8-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scs_div
    import scs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [7:0]  divisor,
    output logic        done,
    output logic [15:0] quotient,
    output logic [7:0]  remainder
);

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [15:0]      quo_reg;
    logic [7:0]       rem_reg;
    logic [7:0]       dsr_reg;
    logic [8:0]       trial;
    logic [8:0]       diff;
    logic             fits;

    assign trial     = {rem_reg, quo_reg[15]};
    assign diff      = trial - {1'b0, dsr_reg};
    assign fits      = (trial >= {1'b0, dsr_reg});
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(DIV_STEPS);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[14:0], fits};
            rem_reg <= fits ? diff[7:0] : trial[7:0];
        end
    end

endmodule

/* hw/rtl/scs_back.sv */
// ----------------------------------------------------------------------------
// scs_back
// Chunk engine: locates the first sector by division, then emits one chunk
// per cylinder into a registered result slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scs_back
    import scs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  geom_t   geom,
    input  logic    q_valid,
    output logic    q_ready,
    input  req_t    q_req,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    localparam result_t ERR_RESULT = '{head: 1'b0, track: 8'd0, sector: 6'd0,
                                       chunk: 7'd0, sel: 3'd0, bad: 1'b1, last: 1'b1};

    state_t      state_reg,     state_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_res_reg,   out_res_next;
    logic [1:0]  drive_reg,     drive_next;
    logic [6:0]  rem_reg,       rem_next;
    logic [7:0]  spc_reg,       spc_next;
    logic [15:0] track_reg,     track_next;
    logic [7:0]  within_reg,    within_next;

    logic        out_free;
    logic        div_start;
    logic        div_done;
    logic [15:0] div_quo;
    logic [7:0]  div_rem;
    logic [7:0]  spc_calc;
    logic [7:0]  spt8;
    logic [7:0]  spt2;
    logic        head;
    logic [7:0]  sec_m1;
    logic [5:0]  sector;
    logic [7:0]  room;
    logic [6:0]  chunk;
    logic [6:0]  rem_after;
    logic        bad;

    assign out_free  = !out_valid_reg || res_ready;
    assign q_ready   = (state_reg == ST_IDLE) && out_free;
    assign div_start = q_valid && q_ready && (q_req.kind == REQ_NORMAL);
    assign res_valid = out_valid_reg;
    assign res       = out_res_reg;

    assign spc_calc = 8'({2'b00, geom.spt} * {6'd0, geom.heads});

    scs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (q_req.lba),
        .divisor   (spc_calc),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // head and sector within the cylinder, at most three heads
    always_comb
    begin
        spt8 = {2'b00, geom.spt};
        spt2 = {1'b0, geom.spt, 1'b0};
        if (within_reg >= spt2)
        begin
            head   = 1'b0;
            sec_m1 = within_reg - spt2;
        end
        else if (within_reg >= spt8)
        begin
            head   = 1'b1;
            sec_m1 = within_reg - spt8;
        end
        else
        begin
            head   = 1'b0;
            sec_m1 = within_reg;
        end
        sector    = 6'(sec_m1 + 8'd1);
        room      = spc_reg - within_reg;
        chunk     = ({1'b0, rem_reg} < room) ? rem_reg : room[6:0];
        rem_after = rem_reg - chunk;
        bad       = (track_reg >= {8'd0, geom.cyls});
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        drive_next     = drive_reg;
        rem_next       = rem_reg;
        spc_next       = spc_reg;
        track_next     = track_reg;
        within_next    = within_reg;

        if (out_valid_reg && res_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && q_ready)
                begin
                    if (q_req.kind == REQ_ERROR)
                    begin
                        out_valid_next = 1'b1;
                        out_res_next   = ERR_RESULT;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                        drive_next = q_req.drive;
                        rem_next   = q_req.count;
                        spc_next   = spc_calc;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    track_next  = div_quo;
                    within_next = div_rem;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (bad)
                    begin
                        out_res_next = ERR_RESULT;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        out_res_next.head   = head;
                        out_res_next.track  = track_reg[7:0];
                        out_res_next.sector = sector;
                        out_res_next.chunk  = chunk;
                        out_res_next.sel    = {head, drive_reg};
                        out_res_next.bad    = 1'b0;
                        out_res_next.last   = (rem_after == 7'd0);
                        rem_next            = rem_after;
                        if (rem_after == 7'd0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            track_next  = track_reg + 16'd1;
                            within_next = 8'd0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
        drive_reg   <= drive_next;
        rem_reg     <= rem_next;
        spc_reg     <= spc_next;
        track_reg   <= track_next;
        within_reg  <= within_next;
    end

endmodule

/* hw/rtl/lba_to_chs_cylinder_splitter.sv */
// ----------------------------------------------------------------------------
// lba_to_chs_cylinder_splitter
// Splits a disk transfer request into chunks that stay inside one cylinder.
// ----------------------------------------------------------------------------
// A request enters through a register stage and a two-entry queue, so the
// input keeps taking requests while the chunk engine works. For each request
// with a nonzero count the engine locates the first sector by a 16-step
// restoring division of the logical sector by the cylinder size, then gives
// one chunk per cycle while the output is taken. Requests with a zero
// geometry give their error result without a division; requests with a
// zero count give nothing.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lba_to_chs_cylinder_splitter
    import scs_pkg::*;
#(
    parameter int MAX_COUNT = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // drive[1:0], logical_sector[17:2], sector_count[24:18]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // head[0], track[8:1], sector[14:9],
                                   // chunk_sectors[21:15], select_byte[24:22]
    output logic        m_tlast,
    output logic        m_tuser    // bad_address
);

    geom_t   geom_reg;
    logic    f_valid;
    logic    f_ready;
    req_t    f_req;
    logic    q_valid;
    logic    q_ready;
    req_t    q_req;
    result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg.spt   <= SPT_RESET;
            geom_reg.heads <= HEADS_RESET;
            geom_reg.cyls  <= CYLS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SPT:   geom_reg.spt   <= cfg_data[5:0];
                CFG_HEADS: geom_reg.heads <= cfg_data[1:0];
                CFG_CYLS:  geom_reg.cyls  <= cfg_data;
                default:   ;
            endcase
        end
    end

    scs_front #(
        .MAX_COUNT (MAX_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .geom      (geom_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_drive  (s_tdata[1:0]),
        .in_lba    (s_tdata[17:2]),
        .in_count  (s_tdata[24:18]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_req   (f_req)
    );

    scs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_req    (f_req),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_req   (q_req)
    );

    scs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .geom      (geom_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_req     (q_req),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {7'd0, res.sel, res.chunk, res.sector, res.track, res.head};
    assign m_tlast = res.last;
    assign m_tuser = res.bad;

    `ASSERT_IMPLIES(a_err_is_last, clk, rst_n, m_tvalid && res.bad, res.last)
    `ASSERT_IMPLIES(a_err_empty, clk, rst_n, m_tvalid && res.bad, res.chunk == 7'd0)
    `ASSERT_NEVER(a_chunk_nonzero, clk, rst_n, m_tvalid && !res.bad && res.chunk == 7'd0)
    `ASSERT_NEVER(a_sector_nonzero, clk, rst_n, m_tvalid && !res.bad && res.sector == 6'd0)

endmodule

/* tb/lba_to_chs_cylinder_splitter_tb.sv */
// ----------------------------------------------------------------------------
// lba_to_chs_cylinder_splitter_tb
// Streams disk transfer requests through the cylinder splitter under several
// disk geometries and checks every chunk against an in-bench split of the
// request, with random idle bursts on both stream sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lba_to_chs_cylinder_splitter_tb
    import scs_pkg::*;
;

    localparam int         MAX_SECTORS   = 64;
    localparam int         SETTLE_CYCLES = 100;
    localparam logic [1:0] CFG_UNUSED    = 2'd3;

    // Keeps the geometry and the chunks still owed by the block.
    class chs_scoreboard;
        logic [5:0] spt;
        logic [1:0] heads;
        logic [7:0] cyls;
        result_t    chunks_due[$];
        int         errors;

        function new();
            spt    = SPT_RESET;
            heads  = HEADS_RESET;
            cyls   = CYLS_RESET;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] val);
            case (idx)
                CFG_SPT:   spt = val[5:0];
                CFG_HEADS: heads = val[1:0];
                CFG_CYLS:  cyls = val;
                default:   ;
            endcase
        endfunction

        function int unsigned capacity();
            return int'(spt) * int'(heads) * int'(cyls);
        endfunction

        function int pending();
            return chunks_due.size();
        endfunction

        // Split one accepted request into the chunks the block must emit.
        function void note_request(logic [31:0] data);
            logic [1:0]  drv;
            int unsigned pos, left, sectors, nheads, spc;
            int unsigned offs, hd, trk, room, take;
            result_t     r;
            drv     = data[1:0];
            pos     = data[17:2];
            left    = data[24:18];
            sectors = spt;
            nheads  = heads;
            spc     = sectors * nheads;
            if (left > MAX_SECTORS)
                left = MAX_SECTORS;
            while (left > 0)
            begin
                r = '0;
                if (spc == 0)
                begin
                    r.bad  = 1'b1;
                    r.last = 1'b1;
                    chunks_due.push_back(r);
                    break;
                end
                offs = pos % spc;
                hd   = offs / sectors;
                trk  = pos / spc;
                if (trk >= cyls || hd >= nheads)
                begin
                    r.bad  = 1'b1;
                    r.last = 1'b1;
                    chunks_due.push_back(r);
                    break;
                end
                room     = spc - offs;
                take     = (left < room) ? left : room;
                r.head   = hd[0];
                r.track  = trk[7:0];
                r.sector = 6'((pos % sectors) + 1);
                r.chunk  = take[6:0];
                r.sel    = {hd[0], drv};
                pos      = pos + take;
                left     = left - take;
                r.last   = (left == 0);
                chunks_due.push_back(r);
            end
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            errors++;
            if (errors <= 50)
                $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        endtask

        task check_result(logic [31:0] data, logic lst, logic bad);
            result_t want;
            if (chunks_due.size() == 0)
            begin
                report_mismatch("unexpected chunk, tdata", data, 0);
                return;
            end
            want = chunks_due.pop_front();
            if (data[0] !== want.head)
                report_mismatch("head", data[0], want.head);
            if (data[8:1] !== want.track)
                report_mismatch("track", data[8:1], want.track);
            if (data[14:9] !== want.sector)
                report_mismatch("sector", data[14:9], want.sector);
            if (data[21:15] !== want.chunk)
                report_mismatch("chunk_sectors", data[21:15], want.chunk);
            if (data[24:22] !== want.sel)
                report_mismatch("select_byte", data[24:22], want.sel);
            if (bad !== want.bad)
                report_mismatch("bad_address", bad, want.bad);
            if (lst !== want.last)
                report_mismatch("last", lst, want.last);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // drive[1:0], logical_sector[17:2], sector_count[24:18]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // head[0], track[8:1], sector[14:9],
                            // chunk_sectors[21:15], select_byte[24:22]
    logic        m_tlast;
    logic        m_tuser;   // bad_address

    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;

    chs_scoreboard sb = new();

    lba_to_chs_cylinder_splitter #(
        .MAX_COUNT (MAX_SECTORS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40ms;
        $display("lba_to_chs_cylinder_splitter_tb NOT OK");
        $finish;
    end

    // Both handshakes sampled in one place so a request is noted before its chunks.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast, m_tuser);
        end
    end

    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (sink_idle_en && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_geometry(logic [7:0] spt, logic [7:0] heads, logic [7:0] cyls);
        write_reg(CFG_SPT, spt);
        write_reg(CFG_HEADS, heads);
        write_reg(CFG_CYLS, cyls);
    endtask

    task automatic send_request(logic [1:0] drv, logic [15:0] lba, logic [6:0] cnt);
        if (src_idle_en && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, cnt, lba, drv};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Hold off the source until every owed chunk is out, then let zero-count
    // requests still in the pipe retire.
    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_geometry();
        write_reg(CFG_SPT, ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(1, 63)));
        write_reg(CFG_HEADS, ($urandom_range(0, 5) == 0) ? 8'($urandom)
                                                         : 8'($urandom_range(1, 2)));
        write_reg(CFG_CYLS, ($urandom_range(0, 5) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(1, 255)));
    endtask

    // Mostly in-range addresses, some near the end of the disk, some anywhere.
    task automatic send_random_requests(int n);
        int unsigned span, lba, pick, cnt;
        repeat (n)
        begin
            span = sb.capacity();
            pick = $urandom_range(0, 9);
            if (pick < 6)
                lba = $urandom_range(0, span + 8);
            else if (pick < 8)
                lba = (span > 64) ? span - $urandom_range(0, 64) : $urandom_range(0, 72);
            else
                lba = $urandom_range(0, 65535);
            if (lba > 65535)
                lba = 65535;
            pick = $urandom_range(0, 19);
            if (pick == 0)
                cnt = 0;
            else if (pick == 1)
                cnt = $urandom_range(65, 127);
            else
                cnt = $urandom_range(1, 64);
            send_request(2'($urandom_range(0, 3)), lba[15:0], cnt[6:0]);
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_SPT;
        cfg_data  <= 8'd0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 32'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: 18 sectors, 2 heads, 80 cylinders
        send_request(2'd0, 16'd0, 7'd1);
        send_request(2'd3, 16'd0, 7'd64);
        send_request(2'd1, 16'd35, 7'd2);
        send_request(2'd2, 16'd2879, 7'd5);
        send_request(2'd0, 16'd2880, 7'd1);
        send_request(2'd3, 16'hFFFF, 7'd127);
        send_request(2'd1, 16'd100, 7'd0);
        send_request(2'd2, 16'd200, 7'd65);
        send_request(2'd0, 16'd17, 7'd3);
        send_request(2'd1, 16'd18, 7'd1);

        drain_and_settle();
        write_reg(CFG_UNUSED, 8'hFF);
        send_request(2'd2, 16'd19, 7'd1);

        // zero sectors per track (upper bit masked away)
        drain_and_settle();
        write_reg(CFG_SPT, 8'h40);
        send_request(2'd1, 16'd5, 7'd1);
        send_request(2'd1, 16'd5, 7'd0);

        drain_and_settle();
        write_geometry(8'd18, 8'd0, 8'd80);
        send_request(2'd2, 16'd0, 7'd4);

        // three heads, widest geometry
        drain_and_settle();
        write_geometry(8'd63, 8'd3, 8'd255);
        send_request(2'd3, 16'd48194, 7'd2);
        send_request(2'd0, 16'hFFFF, 7'd1);
        send_request(2'd1, 16'd126, 7'd64);
        send_request(2'd2, 16'd189, 7'd64);

        // one sector per cylinder: one chunk per sector
        drain_and_settle();
        write_geometry(8'd1, 8'd1, 8'd255);
        send_request(2'd3, 16'd0, 7'd64);
        send_request(2'd0, 16'd250, 7'd10);

        drain_and_settle();
        write_reg(CFG_CYLS, 8'd0);
        send_request(2'd1, 16'd0, 7'd1);

        for (int p = 0; p < 8; p++)
        begin
            drain_and_settle();
            random_geometry();
            send_random_requests(50);
        end

        drain_and_settle();
        write_geometry(8'd18, 8'd2, 8'd80);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        send_random_requests(40);
        drain_and_settle();

        if (sb.errors == 0)
            $display("lba_to_chs_cylinder_splitter_tb OK");
        else
            $display("lba_to_chs_cylinder_splitter_tb NOT OK");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/scs_pkg.sv
hw/rtl/scs_front.sv
hw/rtl/scs_queue.sv
hw/rtl/scs_div.sv
hw/rtl/scs_back.sv
hw/rtl/lba_to_chs_cylinder_splitter.sv
tb/lba_to_chs_cylinder_splitter_tb.sv
